FILE: src/smat_pkg.sv
// ============================================================================
// smat_pkg
// Shared constants, codes, types and helpers for the small matrix unit.
// ============================================================================
package smat_pkg;

  localparam int MAX_DIM = 4;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int ADDR_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DIM_W   = 3;
  localparam int DATA_W  = 32;
  localparam int REQ_W   = 3;

  localparam logic [REQ_W-1:0] REQ_LOAD_A    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SUM       = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MUL       = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TRANSPOSE = 3'd4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [DATA_W-1:0] word_t;
  typedef logic [REQ_W-1:0]  req_t;

  typedef struct packed {
    logic  en;
    logic  sel_b;
    addr_t addr;
    word_t data;
  } mem_wr_t;

  typedef struct packed {
    logic  en;
    addr_t a_addr;
    addr_t b_addr;
  } mem_rd_t;

  typedef struct packed {
    logic valid;
    req_t op;
    dim_t rows;
    dim_t cols;
  } op_start_t;

  function automatic dim_t clamp_dim(input dim_t v);
    dim_t r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  function automatic addr_t cell_addr(input idx_t r, input idx_t c);
    return ADDR_W'(r) * ADDR_W'(MAX_DIM) + ADDR_W'(c);
  endfunction

endpackage

FILE: src/smat_if.sv
// ============================================================================
// smat_in_if / smat_out_if
// Valid/ready channels for request beats and result beats.
// ============================================================================
interface smat_in_if;
  import smat_pkg::*;

  logic         valid;
  logic         ready;
  req_t         req_type;
  idx_t         row_index;
  idx_t         col_index;
  logic signed [DATA_W-1:0] element_value;

  modport source (output valid, req_type, row_index, col_index, element_value,
                  input ready);
  modport sink   (input valid, req_type, row_index, col_index, element_value,
                  output ready);
endinterface

interface smat_out_if;
  import smat_pkg::*;

  logic         valid;
  logic         ready;
  idx_t         result_row;
  idx_t         result_col;
  logic signed [DATA_W-1:0] result_value;
  logic         last_result;

  modport source (output valid, result_row, result_col, result_value, last_result,
                  input ready);
  modport sink   (input valid, result_row, result_col, result_value, last_result,
                  output ready);
endinterface

FILE: src/smat_mem.sv
// ============================================================================
// smat_mem
// Element stores for matrices A and B, one write and one registered read each.
// ============================================================================
module smat_mem (
  input  logic              clk,
  input  smat_pkg::mem_wr_t wr,
  input  smat_pkg::mem_rd_t rd,
  output smat_pkg::word_t   a_rdata_r,
  output smat_pkg::word_t   b_rdata_r
);
  import smat_pkg::*;

  word_t a_mem [CELLS];
  word_t b_mem [CELLS];

  always_ff @(posedge clk) begin
    if (wr.en && !wr.sel_b) begin
      a_mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      a_rdata_r <= a_mem[rd.a_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.sel_b) begin
      b_mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      b_rdata_r <= b_mem[rd.b_addr];
    end
  end

endmodule

FILE: src/smat_seq.sv
// ============================================================================
// smat_seq
// Walks the result elements, reads the stores, multiplies, adds or passes A
// through, and accumulates into the result register.
// ============================================================================
module smat_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  smat_pkg::op_start_t start,
  output logic                busy,
  output smat_pkg::mem_rd_t   rd,
  input  smat_pkg::word_t     a_rdata_r,
  input  smat_pkg::word_t     b_rdata_r,
  smat_out_if.source          out_ch
);
  import smat_pkg::*;

  logic  stall;

  logic  active_r;
  req_t  op_r;
  idx_t  i_r, j_r, k_r;
  idx_t  outer_m1_r, inner_m1_r, kmax_r;
  dim_t  rows_c, cols_c;
  idx_t  rows_m1, cols_m1;
  logic  k_end, j_end, i_end;
  idx_t  a_row, a_col, b_row, b_col;

  logic  s1_v_r, s1_first_r, s1_last_r, s1_end_r;
  req_t  s1_op_r;
  idx_t  s1_i_r, s1_j_r;

  logic  s2_v_r, s2_first_r, s2_last_r, s2_end_r;
  idx_t  s2_i_r, s2_j_r;
  word_t s2_val_r;
  word_t s1_val;

  word_t acc_r;
  word_t acc_sum;

  logic  out_v_r;
  idx_t  out_row_r, out_col_r;
  word_t out_val_r;
  logic  out_last_r;

  assign stall = out_v_r && !out_ch.ready;
  assign busy  = active_r;

  assign rows_c  = clamp_dim(start.rows);
  assign cols_c  = clamp_dim(start.cols);
  assign rows_m1 = IDX_W'(rows_c - DIM_W'(1));
  assign cols_m1 = IDX_W'(cols_c - DIM_W'(1));

  assign k_end = (k_r == kmax_r);
  assign j_end = (j_r == inner_m1_r);
  assign i_end = (i_r == outer_m1_r);

  always_comb begin
    a_row = i_r;
    a_col = j_r;
    b_row = i_r;
    b_col = j_r;
    unique case (op_r)
      REQ_MUL: begin
        a_col = k_r;
        b_row = k_r;
      end
      REQ_TRANSPOSE: begin
        a_row = j_r;
        a_col = i_r;
      end
      default: begin
      end
    endcase
  end

  assign rd.en     = active_r && !stall;
  assign rd.a_addr = cell_addr(a_row, a_col);
  assign rd.b_addr = cell_addr(b_row, b_col);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (start.valid) begin
      active_r <= 1'b1;
    end else if (active_r && !stall && k_end && j_end && i_end) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start.valid) begin
      op_r       <= start.op;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      outer_m1_r <= (start.op == REQ_TRANSPOSE) ? cols_m1 : rows_m1;
      inner_m1_r <= (start.op == REQ_TRANSPOSE) ? rows_m1 : cols_m1;
      kmax_r     <= (start.op == REQ_MUL) ? cols_m1 : '0;
    end else if (active_r && !stall) begin
      if (k_end) begin
        k_r <= '0;
        if (j_end) begin
          j_r <= '0;
          i_r <= i_r + IDX_W'(1);
        end else begin
          j_r <= j_r + IDX_W'(1);
        end
      end else begin
        k_r <= k_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (!stall) begin
      s1_v_r <= active_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s1_op_r    <= op_r;
      s1_i_r     <= i_r;
      s1_j_r     <= j_r;
      s1_first_r <= (k_r == '0);
      s1_last_r  <= k_end;
      s1_end_r   <= k_end && j_end && i_end;
    end
  end

  always_comb begin
    unique case (s1_op_r)
      REQ_SUM: s1_val = a_rdata_r + b_rdata_r;
      REQ_MUL: s1_val = a_rdata_r * b_rdata_r;
      default: s1_val = a_rdata_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      s2_val_r   <= s1_val;
      s2_i_r     <= s1_i_r;
      s2_j_r     <= s1_j_r;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_end_r   <= s1_end_r;
    end
  end

  assign acc_sum = (s2_first_r ? '0 : acc_r) + s2_val_r;

  always_ff @(posedge clk) begin
    if (s2_v_r && !stall) begin
      acc_r <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!stall) begin
      out_v_r <= s2_v_r && s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && s2_last_r && !stall) begin
      out_row_r  <= s2_i_r;
      out_col_r  <= s2_j_r;
      out_val_r  <= acc_sum;
      out_last_r <= s2_end_r;
    end
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_row   = out_row_r;
  assign out_ch.result_col   = out_col_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.last_result  = out_last_r;

  a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start.valid |-> !active_r)
    else $error("operation started while the walk is still running");

  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (k_r <= kmax_r))
    else $error("inner index beyond the multiply length");

  a_single_step_ops: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_op_r != REQ_MUL) |-> (s1_first_r && s1_last_r))
    else $error("sum or transpose element spans more than one step");

  a_stall_holds_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && $past(stall)) |-> $stable(s2_val_r))
    else $error("pipeline moved during an output stall");

endmodule

FILE: src/small_matrix_add_mul_transpose.sv
// ============================================================================
// small_matrix_add_mul_transpose
// Small matrix unit: loads elements of A and B, emits A+B, A*B or A^T.
// ============================================================================
//  Channel   Dir  Handshake           Beat contents
//  in_ch     in   valid/ready         req_type, row_index, col_index, element_value
//  out_ch    out  valid/ready         result_row, result_col, result_value, last_result
//  cfg_*     in   APB psel/penable    row_count at 0x0, col_count at 0x4
//
//  A load beat writes one store entry.
//  An operation issues one store read pair per cycle unless a result stalls:
//  rows*cols pairs for sum and transpose, rows*cols*cols for multiply.
//  The rate is set by the single read port of each store feeding one multiply-add.
//  No request beat is taken while an operation is still issuing reads.
//  A stalled result stops the whole pipeline. Reset clears control only.
// ============================================================================
module small_matrix_add_mul_transpose (
  input  logic              clk,
  input  logic              rst_n,
  smat_in_if.sink           in_ch,
  smat_out_if.source        out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import smat_pkg::*;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  dim_t      row_count_r;
  dim_t      col_count_r;
  logic      cfg_wr;
  logic      in_acc;
  logic      busy;
  mem_wr_t   wr;
  mem_rd_t   rd;
  op_start_t start;
  word_t     a_rdata_r;
  word_t     b_rdata_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= DIM_W'(3);
      col_count_r <= DIM_W'(3);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ROW_COUNT: row_count_r <= cfg_pwdata[DIM_W-1:0];
        REG_COL_COUNT: col_count_r <= cfg_pwdata[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_COL_COUNT) ? 32'(col_count_r) : 32'(row_count_r);

  assign in_ch.ready = !busy;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign wr.en    = in_acc && (in_ch.req_type == REQ_LOAD_A || in_ch.req_type == REQ_LOAD_B);
  assign wr.sel_b = (in_ch.req_type == REQ_LOAD_B);
  assign wr.addr  = cell_addr(in_ch.row_index, in_ch.col_index);
  assign wr.data  = in_ch.element_value;

  assign start.valid = in_acc && (in_ch.req_type == REQ_SUM || in_ch.req_type == REQ_MUL ||
                                  in_ch.req_type == REQ_TRANSPOSE);
  assign start.op    = in_ch.req_type;
  assign start.rows  = row_count_r;
  assign start.cols  = col_count_r;

  smat_mem u_mem (
    .clk       (clk),
    .wr        (wr),
    .rd        (rd),
    .a_rdata_r (a_rdata_r),
    .b_rdata_r (b_rdata_r)
  );

  smat_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .rd        (rd),
    .a_rdata_r (a_rdata_r),
    .b_rdata_r (b_rdata_r),
    .out_ch    (out_ch)
  );

endmodule

FILE: bench/tb.sv
// ============================================================================
// tb
// Self-checking bench for the small matrix unit. A scoreboard class keeps its
// own copy of both matrices and of the dimension registers, and predicts every
// result beat of sum, multiply and transpose. Directed loads and operations
// come first, then a fill of both matrices, then random phases under several
// dimension settings, with random gaps on the request side and random stalls
// on the result side.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smat_pkg::*;

  localparam int unsigned REG_ROW_COUNT = 0;
  localparam int unsigned REG_COL_COUNT = 1;
  localparam int unsigned DRAIN_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned PHASE_ITEMS   = 16;

  typedef struct {
    idx_t  row;
    idx_t  col;
    word_t value;
    logic  last;
  } result_beat_t;

  class matrix_result_board;
    word_t        a_cells[MAX_DIM][MAX_DIM];
    word_t        b_cells[MAX_DIM][MAX_DIM];
    dim_t         row_reg;
    dim_t         col_reg;
    result_beat_t pending_elements[$];
    int unsigned  errors;

    function new();
      row_reg = 3'd3;
      col_reg = 3'd3;
      errors  = 0;
    endfunction

    function void set_dim(int unsigned index, dim_t value);
      if (index == REG_ROW_COUNT) begin
        row_reg = value;
      end else if (index == REG_COL_COUNT) begin
        col_reg = value;
      end
    endfunction

    function int unsigned used_dim(dim_t v);
      if (v == 0) begin
        return 1;
      end
      if (v > MAX_DIM) begin
        return MAX_DIM;
      end
      return v;
    endfunction

    function void take_request(req_t req, idx_t ri, idx_t ci, word_t val);
      int unsigned  rows;
      int unsigned  cols;
      int unsigned  outer;
      int unsigned  inner;
      word_t        acc;
      result_beat_t beat;
      rows = used_dim(row_reg);
      cols = used_dim(col_reg);
      case (req)
        REQ_LOAD_A: begin
          a_cells[ri][ci] = val;
        end
        REQ_LOAD_B: begin
          b_cells[ri][ci] = val;
        end
        REQ_SUM, REQ_MUL, REQ_TRANSPOSE: begin
          outer = (req == REQ_TRANSPOSE) ? cols : rows;
          inner = (req == REQ_TRANSPOSE) ? rows : cols;
          for (int i = 0; i < outer; i++) begin
            for (int j = 0; j < inner; j++) begin
              acc = '0;
              if (req == REQ_SUM) begin
                acc = a_cells[i][j] + b_cells[i][j];
              end else if (req == REQ_MUL) begin
                for (int k = 0; k < cols; k++) begin
                  acc = acc + a_cells[i][k] * b_cells[k][j];
                end
              end else begin
                acc = a_cells[j][i];
              end
              beat.row   = idx_t'(i);
              beat.col   = idx_t'(j);
              beat.value = acc;
              beat.last  = (i == outer - 1) && (j == inner - 1);
              pending_elements.push_back(beat);
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(result_beat_t got);
      result_beat_t want;
      if (pending_elements.size() == 0) begin
        $error("unexpected result beat: row %0d col %0d value %0h last %0b",
               got.row, got.col, got.value, got.last);
        errors++;
        return;
      end
      want = pending_elements.pop_front();
      if (got.row !== want.row) begin
        $error("result_row: expected %0d, got %0d", want.row, got.row);
        errors++;
      end
      if (got.col !== want.col) begin
        $error("result_col: expected %0d, got %0d", want.col, got.col);
        errors++;
      end
      if (got.value !== want.value) begin
        $error("result_value: expected %08h, got %08h", want.value, got.value);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last_result: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bit in_gap_on;
  bit out_stall_on;

  matrix_result_board board;

  smat_in_if  in_ch();
  smat_out_if out_ch();

  small_matrix_add_mul_transpose u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
  end

  always #4 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    result_beat_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.row   = out_ch.result_row;
      got.col   = out_ch.result_col;
      got.value = out_ch.result_value;
      got.last  = out_ch.last_result;
      board.check_result(got);
    end
  end

  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      gap = out_stall_on ? $urandom_range(0, 16) : 0;
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return word_t'($urandom_range(0, 31)) - 32'd16;
      default: return $urandom();
    endcase
  endfunction

  // Called at a falling edge; returns at a falling edge with nothing scheduled.
  task automatic send_request(input req_t req, input idx_t ri, input idx_t ci,
                              input word_t val);
    int unsigned gap;
    gap = in_gap_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.req_type      <= req;
    in_ch.row_index     <= ri;
    in_ch.col_index     <= ci;
    in_ch.element_value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    board.take_request(req, ri, ci, val);
    @(negedge clk);
  endtask

  task automatic write_reg(input int unsigned index, input dim_t value);
    logic [31:0] wdata;
    wdata       = $urandom();
    wdata[2:0]  = value;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= 3'(4 * index);
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.set_dim(index, value);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic finish_phase();
    int unsigned waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (board.pending_elements.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_random(output bit counted);
    req_t req;
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll < 9) begin
      req = $urandom_range(0, 1) ? REQ_LOAD_B : REQ_LOAD_A;
    end else if (roll < 18) begin
      case ($urandom_range(0, 2))
        0: req = REQ_SUM;
        1: req = REQ_MUL;
        default: req = REQ_TRANSPOSE;
      endcase
    end else begin
      req = req_t'($urandom_range(REQ_TRANSPOSE + 1, (1 << REQ_W) - 1));
    end
    counted = (req <= REQ_TRANSPOSE);
    send_request(req, idx_t'($urandom_range(0, MAX_DIM - 1)),
                 idx_t'($urandom_range(0, MAX_DIM - 1)), pick_word());
  endtask

  task automatic run_phase(input dim_t rows, input dim_t cols);
    int unsigned done;
    bit          counted;
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    in_gap_on    = ($urandom_range(0, 3) != 0);
    out_stall_on = ($urandom_range(0, 3) != 0);
    done = 0;
    while (done < PHASE_ITEMS) begin
      send_random(counted);
      if (counted) begin
        done++;
      end
    end
    finish_phase();
  endtask

  initial begin
    static word_t dir_a[9] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                               32'h0000_0000, 32'h0000_0001, 32'h5555_5555,
                               32'hAAAA_AAAA, 32'h0001_0000, 32'hFFFF_FFFE};
    static word_t dir_b[9] = '{32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                               32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA,
                               32'h0000_0000, 32'h0001_0000, 32'h8000_0001};
    static dim_t phase_rows[8] = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd4, 3'd2, 3'd5, 3'd6};
    static dim_t phase_cols[8] = '{3'd0, 3'd4, 3'd6, 3'd4, 3'd1, 3'd3, 3'd2, 3'd7};
    int unsigned fill_order[2 * CELLS];
    int unsigned swap_at;
    int unsigned code;
    int unsigned spot;

    board = new();
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.req_type      = REQ_LOAD_A;
    in_ch.row_index     = '0;
    in_ch.col_index     = '0;
    in_ch.element_value = '0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
    in_gap_on           = 1'b1;
    out_stall_on        = 1'b1;

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset dimensions are 3 by 3: load that corner of both matrices with edge values.
    for (int i = 0; i < 9; i++) begin
      send_request(REQ_LOAD_A, idx_t'(i / 3), idx_t'(i % 3), dir_a[i]);
      send_request(REQ_LOAD_B, idx_t'(i / 3), idx_t'(i % 3), dir_b[i]);
    end
    send_request(REQ_LOAD_A, idx_t'(MAX_DIM - 1), idx_t'(MAX_DIM - 1), 32'h7FFF_FFFF);
    for (int u = REQ_TRANSPOSE + 1; u < (1 << REQ_W); u++) begin
      send_request(req_t'(u), idx_t'(MAX_DIM - 1), idx_t'(MAX_DIM - 1), 32'hFFFF_FFFF);
    end
    send_request(REQ_SUM, '0, '0, '0);
    send_request(REQ_MUL, '0, '0, '0);
    send_request(REQ_TRANSPOSE, '0, '0, '0);
    finish_phase();

    // Fill every cell of both matrices in random order so that any later shape reads
    // only written entries.
    for (int i = 0; i < 2 * CELLS; i++) begin
      fill_order[i] = i;
    end
    for (int i = 2 * CELLS - 1; i > 0; i--) begin
      swap_at = $urandom_range(0, i);
      code = fill_order[i];
      fill_order[i] = fill_order[swap_at];
      fill_order[swap_at] = code;
    end
    for (int i = 0; i < 2 * CELLS; i++) begin
      spot = fill_order[i] % CELLS;
      send_request((fill_order[i] < CELLS) ? REQ_LOAD_A : REQ_LOAD_B,
                   idx_t'(spot / MAX_DIM), idx_t'(spot % MAX_DIM), pick_word());
    end
    finish_phase();

    for (int p = 0; p < 8; p++) begin
      run_phase(phase_rows[p], phase_cols[p]);
    end
    run_phase(dim_t'($urandom_range(0, 7)), dim_t'($urandom_range(0, 7)));

    if (board.pending_elements.size() != 0) begin
      $error("%0d expected result beats never arrived", board.pending_elements.size());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
